FILE: rtl/core/sgtr_pkg.sv
package sgtr_pkg;

  localparam int GLYPH_N   = 8;
  localparam int MASK_W    = 64;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHAR_NEWLINE  = 8'h0A;
  localparam logic [7:0] CHAR_PRINT_LO = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

  localparam logic [12:0] MAX_DIM      = 13'd4096;
  localparam logic [3:0]  MAX_SCALE    = 4'd8;

  typedef enum logic [1:0] {
    REG_BOX_WIDTH   = 2'd0,
    REG_BOX_HEIGHT  = 2'd1,
    REG_GLYPH_SCALE = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_index_t;

  // Configuration as held: dimensions already saturated, scale stored minus one.
  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [2:0]  scale_m1;
  } cfg_t;

  // One unit of back-end work: either a glyph to draw or a stop status word.
  typedef struct packed {
    logic        is_status;
    logic [11:0] x;
    logic [13:0] y;
    logic [63:0] lanes;
    logic [63:0] glyph;
  } job_t;

  // Magnifies one glyph row horizontally by scale_m1 + 1.
  function automatic logic [63:0] expand_row(input logic [7:0] bits,
                                             input logic [2:0] scale_m1);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < MASK_W; i++) begin
      unique case (scale_m1)
        3'd0: r[i] = bits[3'(i / 1)];
        3'd1: r[i] = bits[3'(i / 2)];
        3'd2: r[i] = bits[3'(i / 3)];
        3'd3: r[i] = bits[3'(i / 4)];
        3'd4: r[i] = bits[3'(i / 5)];
        3'd5: r[i] = bits[3'(i / 6)];
        3'd6: r[i] = bits[3'(i / 7)];
        3'd7: r[i] = bits[3'(i / 8)];
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sgtr_front.sv
module sgtr_front
  import sgtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        s_tuser,
  input  logic        q_full,
  output logic        q_push,
  output job_t        q_data
);

  logic [12:0] cursor_x, cursor_x_next;
  logic [13:0] cursor_y, cursor_y_next;
  logic        stopped, stopped_next;

  logic [7:0]  char_code;
  logic        accept;
  logic        emit;
  logic [6:0]  cell_sz;
  logic [12:0] cx0;
  logic [13:0] cy0;
  logic        st0;
  logic [14:0] brk_y;
  logic        brk_stop;
  logic        wrap;
  logic        printable;
  logic [12:0] cxw;
  logic [13:0] cyw;
  logic [13:0] avail;
  logic [6:0]  lim;

  assign char_code = s_tdata[7:0];
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign q_push    = accept && emit;

  always_comb begin
    cell_sz   = {1'b0, ({1'b0, cfg.scale_m1} + 4'd1), 2'b00} << 1;
    cx0       = s_tuser ? 13'd0 : cursor_x;
    cy0       = s_tuser ? 14'd0 : cursor_y;
    st0       = s_tuser ? 1'b0 : stopped;
    brk_y     = {1'b0, cy0} + {8'd0, cell_sz};
    brk_stop  = ({1'b0, brk_y} + {9'd0, cell_sz}) > {3'd0, cfg.height};
    wrap      = ({1'b0, cx0} + {7'd0, cell_sz}) > {1'b0, cfg.width};
    printable = (char_code >= CHAR_PRINT_LO) && (char_code <= CHAR_PRINT_HI);
    cxw       = wrap ? 13'd0 : cx0;
    cyw       = wrap ? brk_y[13:0] : cy0;
    // Columns left in the box from the glyph origin, capped at the cell size.
    avail     = (cxw >= cfg.width) ? 14'd0 : ({1'b0, cfg.width} - {1'b0, cxw});
    lim       = (avail > {7'd0, cell_sz}) ? cell_sz : avail[6:0];
  end

  always_comb begin
    cursor_x_next  = cx0;
    cursor_y_next  = cy0;
    stopped_next   = st0;
    emit           = 1'b0;
    q_data         = '0;
    q_data.is_status = 1'b1;
    q_data.glyph   = s_tdata[71:8];
    if (st0) begin
      emit = 1'b1;
    end else if (char_code == CHAR_NEWLINE) begin
      cursor_x_next = 13'd0;
      cursor_y_next = brk_y[13:0];
      stopped_next  = brk_stop;
      emit          = brk_stop;
    end else if (wrap && brk_stop) begin
      cursor_x_next = 13'd0;
      cursor_y_next = brk_y[13:0];
      stopped_next  = 1'b1;
      emit          = 1'b1;
    end else begin
      cursor_x_next    = cxw + {6'd0, cell_sz};
      cursor_y_next    = cyw;
      emit             = printable;
      q_data.is_status = 1'b0;
      q_data.x         = cxw[11:0];
      q_data.y         = cyw;
      for (int i = 0; i < MASK_W; i++) begin
        q_data.lanes[i] = 7'(i) < lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      stopped  <= 1'b0;
    end else if (accept) begin
      cursor_x <= cursor_x_next;
      cursor_y <= cursor_y_next;
      stopped  <= stopped_next;
    end
  end

endmodule

FILE: rtl/core/sgtr_queue.sv
module sgtr_queue
  import sgtr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output logic valid,
  output job_t pop_data
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full     = count == QCNT_W'(QDEPTH);
  assign valid    = count != '0;
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && !valid))
    else $error("job queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("job queue count out of range");
`endif

endmodule

FILE: rtl/core/sgtr_back.sv
module sgtr_back
  import sgtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  job_t        q_data,
  output logic        q_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  logic        busy;
  job_t        job;
  logic [5:0]  row_cnt;
  logic [2:0]  sub;
  logic [2:0]  grow;

  logic        out_valid;
  logic [11:0] out_x;
  logic [12:0] out_y;
  logic [63:0] out_mask;
  logic        out_stopped;
  logic        out_last;

  logic        load;
  logic        last_now;
  logic [5:0]  row_end;
  logic [7:0]  bits;
  logic [14:0] py;
  logic        row_in;
  logic [63:0] mask;

  assign row_end  = {cfg.scale_m1, 3'b111};
  assign load     = !out_valid || m_tready;
  assign last_now = job.is_status || (row_cnt == row_end);
  assign q_pop    = q_valid && (!busy || (load && last_now));

  always_comb begin
    bits   = job.glyph[{grow, 3'b000} +: 8];
    py     = {1'b0, job.y} + {9'd0, row_cnt};
    row_in = py < {2'b00, cfg.height};
    mask   = row_in ? (expand_row(bits, cfg.scale_m1) & job.lanes) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= busy;
      end
      if (q_pop) begin
        busy <= 1'b1;
      end else if (load && busy && last_now) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job     <= q_data;
      row_cnt <= '0;
      sub     <= '0;
      grow    <= '0;
    end else if (load && busy) begin
      row_cnt <= row_cnt + 1'b1;
      // Each glyph row repeats scale times before the next one is used.
      if (sub == cfg.scale_m1) begin
        sub  <= '0;
        grow <= grow + 1'b1;
      end else begin
        sub <= sub + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && busy) begin
      if (job.is_status) begin
        out_x       <= '0;
        out_y       <= '0;
        out_mask    <= '0;
        out_stopped <= 1'b1;
        out_last    <= 1'b1;
      end else begin
        out_x       <= job.x;
        out_y       <= py[12:0];
        out_mask    <= mask;
        out_stopped <= 1'b0;
        out_last    <= row_cnt == row_end;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_mask, out_y, out_x};
  assign m_tuser  = out_stopped;
  assign m_tlast  = out_last;

`ifndef NO_ASSERTIONS
  a_row_in_cell: assert property (@(posedge clk) disable iff (rst)
    (busy && !job.is_status) |-> (row_cnt <= row_end))
    else $error("row counter ran past the glyph cell");
  a_status_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stopped) |-> (out_last && out_mask == '0))
    else $error("status word carries pixels or misses last");
  a_pop_only_idle_or_done: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!busy || last_now))
    else $error("new job taken before the current one finished");
`endif

endmodule

FILE: rtl/core/scaled_glyph_text_rasterizer_unit.sv
// Text rasterizer: each input word carries a character code and its 8x8 glyph rows; the
// block lays characters out in a box of box_width x box_height pixels and emits one
// output word per pixel row of each drawn character, 8*scale words per character, top
// row first, at one word per cycle while the output is ready. The front end takes one
// input word per cycle while the queue has room and updates the cursor; newlines, wraps
// and nonprintable codes emit nothing of their own unless layout stops. Jobs wait in a
// four-entry queue; the row emitter sets throughput, taking each next job with the last
// row of the one before. Box sizes saturate at 4096, the scale clamps to 1..8 on write.
// Configuration should be written only when no output is pending.
module scaled_glyph_text_rasterizer_unit
  import sgtr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // char_code, glyph_row_0 .. glyph_row_7
  input  logic        s_tuser,   // first_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // row_x, row_y, row_mask, zero fill
  output logic        m_tuser,   // layout_stopped
  output logic        m_tlast,   // last_row
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  job_t q_push_data;
  logic q_pop;
  logic q_valid;
  job_t q_pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width    <= 13'd256;
      cfg.height   <= 13'd64;
      cfg.scale_m1 <= 3'd0;
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_BOX_WIDTH: begin
          cfg.width <= (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;
        end
        REG_BOX_HEIGHT: begin
          cfg.height <= (cfg_data > MAX_DIM) ? MAX_DIM : cfg_data;
        end
        REG_GLYPH_SCALE: begin
          if (cfg_data[3:0] == 4'd0) begin
            cfg.scale_m1 <= 3'd0;
          end else if (cfg_data[3:0] > MAX_SCALE) begin
            cfg.scale_m1 <= 3'(MAX_SCALE - 4'd1);
          end else begin
            cfg.scale_m1 <= 3'(cfg_data[3:0] - 4'd1);
          end
        end
        REG_UNUSED: begin
        end
      endcase
    end
  end

  sgtr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  sgtr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_pop_data)
  );

  sgtr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_data   (q_pop_data),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

FILE: bench/tb_scaled_glyph_text_rasterizer_unit.sv
`timescale 1ns / 100ps

module tb_scaled_glyph_text_rasterizer_unit
  import sgtr_pkg::*;
;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_CHARS = 170;
  localparam int MAX_REPORTS = 30;

  typedef enum {BY_MODEL, NO_ROWS, STOP_WORD} typed_t;

  typedef struct packed {
    logic [11:0] x;
    logic [12:0] y;
    logic [63:0] mask;
    logic        stopped;
    logic        last;
  } pix_row_t;

  typedef struct {
    bit          is_cfg;
    reg_index_t  idx;
    logic [12:0] val;
    logic [7:0]  code;
    bit          first;
    logic [63:0] glyph;
    typed_t      typed;
  } text_step_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;   // char_code, glyph_row_0 .. glyph_row_7
  logic        s_tuser;   // first_of_text
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;   // row_x, row_y, row_mask, zero fill
  logic        m_tuser;   // layout_stopped
  logic        m_tlast;   // last_row
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [12:0] cfg_data;

  scaled_glyph_text_rasterizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow of the block's registers and layout state.
  logic [12:0] box_w = 13'd256;
  logic [12:0] box_h = 13'd64;
  logic [3:0]  scale_reg = 4'd1;
  logic [12:0] cur_x = '0;
  logic [13:0] cur_y = '0;
  bit          halted = 1'b0;

  pix_row_t    pending_rows[$];
  text_step_t  text_plan[$];

  int err_count = 0;
  int cycle_count = 0;
  int chars_sent = 0;
  int directed_chars = 0;
  int rows_seen = 0;
  int stop_words = 0;
  int cfg_writes = 0;
  int snk_wait = 0;
  bit quiet_src = 1'b0;
  bit quiet_snk = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still pending", cycle_count,
               pending_rows.size());
      $display("[scaled_glyph_text_rasterizer_unit] ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < MAX_REPORTS)
      $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
    err_count++;
  endtask

  function automatic pix_row_t stop_word();
    pix_row_t w;
    w = '0;
    w.stopped = 1'b1;
    w.last = 1'b1;
    return w;
  endfunction

  // Moves the cursor to the next text line; returns 1 once layout has stopped.
  function automatic bit next_line(input int unsigned cell_sz, input int unsigned ht);
    cur_x = '0;
    cur_y = 14'(cur_y + cell_sz);
    if (cur_y + cell_sz > ht) halted = 1'b1;
    return halted;
  endfunction

  task automatic rasterize_char(input logic [7:0] code, input bit first,
                                input logic [63:0] glyph);
    int unsigned s, cell_sz, wd, ht, py;
    logic [7:0] bits;
    pix_row_t w;
    s = scale_reg;
    if (s < 1) s = 1;
    if (s > MAX_SCALE) s = MAX_SCALE;
    cell_sz = GLYPH_N * s;
    wd = (box_w > MAX_DIM) ? MAX_DIM : box_w;
    ht = (box_h > MAX_DIM) ? MAX_DIM : box_h;
    if (first) begin
      cur_x = '0;
      cur_y = '0;
      halted = 1'b0;
    end
    if (halted) begin
      pending_rows.push_back(stop_word());
      return;
    end
    if (code == CHAR_NEWLINE) begin
      if (next_line(cell_sz, ht)) pending_rows.push_back(stop_word());
      return;
    end
    if (cur_x + cell_sz > wd) begin
      if (next_line(cell_sz, ht)) begin
        pending_rows.push_back(stop_word());
        return;
      end
    end
    if (code < CHAR_PRINT_LO || code > CHAR_PRINT_HI) begin
      cur_x = 13'(cur_x + cell_sz);
      return;
    end
    for (int unsigned r = 0; r < cell_sz; r++) begin
      py = cur_y + r;
      bits = glyph[8 * ((r / s) % GLYPH_N) +: 8];
      w = '0;
      w.x = cur_x[11:0];
      w.y = py[12:0];
      if (py < ht) begin
        for (int unsigned i = 0; i < cell_sz; i++)
          if (bits[i / s] && (cur_x + i < wd)) w.mask[i] = 1'b1;
      end
      w.last = (r + 1 == cell_sz);
      pending_rows.push_back(w);
    end
    cur_x = 13'(cur_x + cell_sz);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [12:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BOX_WIDTH:   box_w = val;
      REG_BOX_HEIGHT:  box_h = val;
      REG_GLYPH_SCALE: scale_reg = val[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
  endtask

  // Lets every pending word out, then lets work that yields nothing settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_char(input logic [7:0] code, input bit first,
                           input logic [63:0] glyph, input typed_t typed);
    int gap;
    int depth;
    gap = quiet_src ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {glyph, code};
    s_tuser  <= first;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    depth = pending_rows.size();
    rasterize_char(code, first, glyph);
    // Rows whose outcome is obvious carry their own expectation instead.
    if (typed != BY_MODEL) begin
      while (pending_rows.size() > depth) void'(pending_rows.pop_back());
      if (typed == STOP_WORD) pending_rows.push_back(stop_word());
    end
    if (pending_rows.size() > depth && pending_rows[$].stopped) stop_words++;
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic plan_cfg(input reg_index_t idx, input logic [12:0] val);
    text_step_t st;
    st = '{is_cfg: 1'b1, idx: idx, val: val, code: '0, first: 1'b0, glyph: '0,
           typed: BY_MODEL};
    text_plan.push_back(st);
  endtask

  task automatic plan_char(input logic [7:0] code, input bit first,
                           input logic [63:0] glyph, input typed_t typed);
    text_step_t st;
    st = '{is_cfg: 1'b0, idx: REG_BOX_WIDTH, val: '0, code: code, first: first,
           glyph: glyph, typed: typed};
    text_plan.push_back(st);
  endtask

  function automatic logic [63:0] rand_glyph();
    return {$urandom, $urandom};
  endfunction

  // Output checker: compare each accepted word against the oldest expectation.
  pix_row_t want_row;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      snk_wait = quiet_snk ? 0 : $urandom_range(0, 15);
      rows_seen++;
      if (pending_rows.size() == 0) begin
        report_mismatch("output word with nothing pending", m_tdata[63:0], '0);
      end else begin
        want_row = pending_rows.pop_front();
        if (m_tdata[11:0] !== want_row.x)
          report_mismatch("row_x", m_tdata[11:0], want_row.x);
        if (m_tdata[24:12] !== want_row.y)
          report_mismatch("row_y", m_tdata[24:12], want_row.y);
        if (m_tdata[88:25] !== want_row.mask)
          report_mismatch("row_mask", m_tdata[88:25], want_row.mask);
        if (m_tuser !== want_row.stopped)
          report_mismatch("layout_stopped", m_tuser, want_row.stopped);
        if (m_tlast !== want_row.last)
          report_mismatch("last_row", m_tlast, want_row.last);
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (snk_wait > 0) begin
        m_tready <= 1'b0;
        snk_wait--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    int n;
    bit in_cfg;
    logic [7:0] code;
    bit first;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_BOX_WIDTH;
    cfg_data = '0;
    in_cfg = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, starting from the reset setting of 256 x 64 at scale one.
    plan_char(CHAR_NEWLINE, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(8'h41, 1'b1, rand_glyph(), BY_MODEL);
    plan_char(CHAR_PRINT_LO, 1'b0, '0, BY_MODEL);
    plan_char(CHAR_PRINT_HI, 1'b0, '1, BY_MODEL);
    plan_char(8'h1F, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(8'h7F, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(8'h00, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(8'hFF, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(CHAR_NEWLINE, 1'b0, rand_glyph(), NO_ROWS);
    // Zero width wraps every character and blanks the mask; scale zero acts as one.
    plan_cfg(REG_GLYPH_SCALE, 13'd0);
    plan_cfg(REG_BOX_WIDTH, 13'd0);
    plan_cfg(REG_UNUSED, 13'h1FFF);
    plan_char(8'h5A, 1'b1, '1, BY_MODEL);
    // Zero height stops layout on the first line break.
    plan_cfg(REG_BOX_HEIGHT, 13'd0);
    plan_char(8'h41, 1'b1, rand_glyph(), STOP_WORD);
    plan_char(8'h42, 1'b0, rand_glyph(), STOP_WORD);
    plan_char(CHAR_NEWLINE, 1'b0, rand_glyph(), STOP_WORD);
    // Oversized box and scale saturate.
    plan_cfg(REG_BOX_WIDTH, 13'h1FFF);
    plan_cfg(REG_BOX_HEIGHT, 13'h1FFF);
    plan_cfg(REG_GLYPH_SCALE, 13'd15);
    plan_char(CHAR_PRINT_HI, 1'b1, rand_glyph(), BY_MODEL);
    plan_char(CHAR_NEWLINE, 1'b0, rand_glyph(), NO_ROWS);
    plan_char(8'h21, 1'b0, rand_glyph(), BY_MODEL);
    // Box narrower than a glyph: wrap, clip on x, then stop on the third wrap.
    plan_cfg(REG_BOX_WIDTH, 13'd20);
    plan_cfg(REG_BOX_HEIGHT, 13'd100);
    plan_cfg(REG_GLYPH_SCALE, 13'd4);
    plan_char(8'h48, 1'b1, '1, BY_MODEL);
    plan_char(8'h49, 1'b0, rand_glyph(), BY_MODEL);
    plan_char(8'h4A, 1'b0, rand_glyph(), STOP_WORD);
    // Box shorter than a glyph: rows below the box are blanked.
    plan_cfg(REG_BOX_WIDTH, 13'd4096);
    plan_cfg(REG_BOX_HEIGHT, 13'd10);
    plan_cfg(REG_GLYPH_SCALE, 13'd2);
    plan_char(8'h4B, 1'b1, '1, BY_MODEL);
    plan_char(CHAR_NEWLINE, 1'b0, rand_glyph(), STOP_WORD);
    plan_cfg(REG_BOX_HEIGHT, 13'd4096);
    plan_cfg(REG_BOX_WIDTH, 13'd1);
    plan_cfg(REG_GLYPH_SCALE, 13'd8);
    plan_char(8'h40, 1'b1, '1, BY_MODEL);
    plan_cfg(REG_BOX_WIDTH, 13'd256);
    plan_cfg(REG_BOX_HEIGHT, 13'd64);
    plan_cfg(REG_GLYPH_SCALE, 13'd1);
    plan_char(8'h30, 1'b1, rand_glyph(), BY_MODEL);

    foreach (text_plan[k]) begin
      if (text_plan[k].is_cfg) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        cfg_write(text_plan[k].idx, text_plan[k].val);
      end else begin
        if (in_cfg) cfg_wr_en <= 1'b0;
        in_cfg = 1'b0;
        send_char(text_plan[k].code, text_plan[k].first, text_plan[k].glyph,
                  text_plan[k].typed);
      end
    end
    directed_chars = chars_sent;

    // Random part: short texts under changing box settings, mostly printable.
    while (chars_sent - directed_chars < RANDOM_CHARS) begin
      drain();
      quiet_src = ($urandom_range(0, 3) == 0);
      quiet_snk = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0:       cfg_write(REG_BOX_WIDTH, 13'd0);
        1:       cfg_write(REG_BOX_WIDTH, 13'($urandom_range(4096, 8191)));
        2:       cfg_write(REG_BOX_WIDTH, 13'($urandom_range(0, 8191)));
        default: cfg_write(REG_BOX_WIDTH, 13'($urandom_range(1, 300)));
      endcase
      case ($urandom_range(0, 9))
        0:       cfg_write(REG_BOX_HEIGHT, 13'd0);
        1:       cfg_write(REG_BOX_HEIGHT, 13'($urandom_range(4096, 8191)));
        2:       cfg_write(REG_BOX_HEIGHT, 13'($urandom_range(0, 8191)));
        default: cfg_write(REG_BOX_HEIGHT, 13'($urandom_range(1, 200)));
      endcase
      case ($urandom_range(0, 9))
        0:       cfg_write(REG_GLYPH_SCALE, 13'd0);
        1:       cfg_write(REG_GLYPH_SCALE, 13'({$urandom_range(0, 511), 4'($urandom_range(9, 15))}));
        2:       cfg_write(REG_GLYPH_SCALE, 13'd8);
        3:       cfg_write(REG_GLYPH_SCALE, 13'($urandom_range(3, 7)));
        default: cfg_write(REG_GLYPH_SCALE, 13'($urandom_range(1, 2)));
      endcase
      if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 13'($urandom_range(0, 8191)));
      cfg_wr_en <= 1'b0;
      n = $urandom_range(8, 24);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 19))
          0, 1, 2: code = CHAR_NEWLINE;
          3:       code = 8'($urandom_range(0, 255));
          4:       code = 8'($urandom_range(8'h7F, 8'hFF));
          default: code = 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
        endcase
        if (k == 0) first = ($urandom_range(0, 3) != 0);
        else        first = ($urandom_range(0, 19) == 0);
        send_char(code, first, rand_glyph(), BY_MODEL);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_rows.size() != 0)
      report_mismatch("words never delivered", pending_rows.size(), '0);

    $display("sent %0d characters (%0d directed) over %0d register writes",
             chars_sent, directed_chars, cfg_writes);
    $display("checked %0d output words, %0d of them stop words, %0d mismatches",
             rows_seen, stop_words, err_count);
    if (err_count == 0) begin
      $display("[scaled_glyph_text_rasterizer_unit] OK");
    end else begin
      $display("[scaled_glyph_text_rasterizer_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/sgtr_pkg.sv
rtl/core/sgtr_front.sv
rtl/core/sgtr_queue.sv
rtl/core/sgtr_back.sv
rtl/core/scaled_glyph_text_rasterizer_unit.sv
bench/tb_scaled_glyph_text_rasterizer_unit.sv
